### design/rh261_pkg.sv
package rh261_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ABORT = 2'd2;

    // Payload header is four bytes; byte position saturates here
    localparam logic [2:0] HDR_BYTES = 3'd4;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int MAXRES = 3;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } t_result;

endpackage

### design/rh261_if.sv
interface rh261_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  in_byte;
    logic        packet_first;
    logic        packet_last;
    logic        marker;
    logic [31:0] rtp_timestamp;

    modport source (
        output valid, in_byte, packet_first, packet_last, marker, rtp_timestamp,
        input  ready
    );
    modport sink (
        input  valid, in_byte, packet_first, packet_last, marker, rtp_timestamp,
        output ready
    );
endinterface

interface rh261_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    modport source (
        output valid, out_byte, kind, run_last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, kind, run_last,
        output ready
    );
endinterface

### design/rtp_h261_depacketizer.sv
// Results of an accepted byte are registered into the result queue, read out in order.
// Throughput: one payload byte per cycle while o_out drains and each byte yields at
// most one result. A byte that yields two or three results (marker flush) drops
// i_in.ready until the four-entry result queue drains back to one entry.
// Reset (synchronous, active low) closes any frame, clears header and bit-carry state,
// and empties the result queue.
module rtp_h261_depacketizer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rh261_in_if.sink     i_in,
    rh261_out_if.source  o_out
);
    import rh261_pkg::*;

    // Parser / accumulator state
    logic        r_frame_open,  n_frame_open;
    logic [31:0] r_frame_stamp, n_frame_stamp;
    logic [31:0] r_pkt_stamp,   n_pkt_stamp;
    logic [2:0]  r_pos,         n_pos;
    logic [2:0]  r_sbit,        n_sbit;
    logic [2:0]  r_ebit,        n_ebit;
    logic        r_hdr_start,   n_hdr_start;
    logic        r_skipped,     n_skipped;
    logic [7:0]  r_carry,       n_carry;
    logic [2:0]  r_carry_cnt,   n_carry_cnt;

    // Results of the current request
    t_result     res [MAXRES];
    logic [1:0]  n_res;

    // Result queue
    t_result     r_q [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;

    logic accept, pop;

    assign i_in.ready = (r_count <= (QAW+1)'(1));
    assign accept = i_in.valid && i_in.ready;
    assign pop    = o_out.valid && o_out.ready;

    assign o_out.valid    = (r_count != '0);
    assign o_out.out_byte = r_q[r_rd].data;
    assign o_out.kind     = r_q[r_rd].kind;
    assign o_out.run_last = r_q[r_rd].last;

    always_comb begin
        logic [7:0]  b;
        logic [2:0]  e;
        logic [3:0]  se;
        logic [3:0]  nb;
        logic [3:0]  total;
        logic [4:0]  sh;
        logic [15:0] mask;
        logic [15:0] dat;
        logic [15:0] w;

        b  = i_in.in_byte;
        e  = '0;
        se = '0;
        nb = '0;
        total = '0;
        sh = '0;
        mask = '0;
        dat = '0;
        w = '0;

        n_frame_open  = r_frame_open;
        n_frame_stamp = r_frame_stamp;
        n_pkt_stamp   = r_pkt_stamp;
        n_pos         = r_pos;
        n_sbit        = r_sbit;
        n_ebit        = r_ebit;
        n_hdr_start   = r_hdr_start;
        n_skipped     = r_skipped;
        n_carry       = r_carry;
        n_carry_cnt   = r_carry_cnt;
        n_res         = '0;
        for (int k = 0; k < MAXRES; k++) begin
            res[k] = '{data: 8'h00, kind: KIND_DATA, last: 1'b0};
        end

        if (i_in.packet_first) begin
            n_pos       = '0;
            n_skipped   = 1'b0;
            n_pkt_stamp = i_in.rtp_timestamp;
            // timestamp change ends the open frame
            if (r_frame_open && (r_frame_stamp != i_in.rtp_timestamp)) begin
                n_frame_open = 1'b0;
                n_carry      = '0;
                n_carry_cnt  = '0;
                res[n_res]   = '{data: 8'h00, kind: KIND_ABORT, last: 1'b0};
                n_res        = n_res + 2'd1;
            end
        end

        if (!n_skipped) begin
            if (n_pos < HDR_BYTES) begin
                case (n_pos)
                    3'd0: begin
                        n_sbit      = b[7:5];
                        n_ebit      = b[4:2];
                        n_hdr_start = (b[7:5] == 3'd0);
                    end
                    3'd1: begin
                        if (b != 8'h00) n_hdr_start = 1'b0;
                    end
                    3'd2: begin
                        if (b[7] || (b[6:2] != 5'd0)) n_hdr_start = 1'b0;
                    end
                    default: ;
                endcase
                n_pos = n_pos + 3'd1;
                if (i_in.packet_last) n_skipped = 1'b1;
            end else begin
                if (!n_frame_open) begin
                    if (n_hdr_start) begin
                        n_frame_open  = 1'b1;
                        n_frame_stamp = n_pkt_stamp;
                        n_carry       = '0;
                        n_carry_cnt   = '0;
                    end else begin
                        n_skipped = 1'b1;
                    end
                end
                if (n_frame_open) begin
                    e     = i_in.packet_last ? n_ebit : 3'd0;
                    se    = {1'b0, n_sbit} + {1'b0, e};
                    nb    = (se >= 4'd8) ? 4'd0 : (4'd8 - se);
                    total = {1'b0, n_carry_cnt} + nb;
                    sh    = 5'd16 - {2'b00, n_carry_cnt} - {1'b0, nb};
                    mask  = (16'd1 << nb) - 16'd1;
                    dat   = {8'h00, (b >> e)} & mask;
                    w     = {n_carry, 8'h00};
                    if (nb != 4'd0) w = w | (dat << sh);
                    if (total >= 4'd8) begin
                        res[n_res]  = '{data: w[15:8], kind: KIND_DATA, last: 1'b0};
                        n_res       = n_res + 2'd1;
                        n_carry     = w[7:0];
                        n_carry_cnt = 3'(total - 4'd8);
                    end else begin
                        n_carry     = w[15:8];
                        n_carry_cnt = total[2:0];
                    end
                    n_sbit = '0;
                    // marker: flush partial byte and close the frame
                    if (i_in.packet_last && i_in.marker) begin
                        if (n_carry_cnt != 3'd0) begin
                            res[n_res] = '{data: n_carry, kind: KIND_DATA, last: 1'b0};
                            n_res      = n_res + 2'd1;
                        end
                        res[n_res]   = '{data: 8'h00, kind: KIND_DONE, last: 1'b0};
                        n_res        = n_res + 2'd1;
                        n_frame_open = 1'b0;
                        n_carry      = '0;
                        n_carry_cnt  = '0;
                    end
                end
                if (i_in.packet_last) n_skipped = 1'b1;
            end
        end

        for (int k = 0; k < MAXRES; k++) begin
            res[k].last = (2'(k) == n_res - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open  <= 1'b0;
            r_frame_stamp <= '0;
            r_pkt_stamp   <= '0;
            r_pos         <= '0;
            r_sbit        <= '0;
            r_ebit        <= '0;
            r_hdr_start   <= 1'b0;
            r_skipped     <= 1'b0;
            r_carry       <= '0;
            r_carry_cnt   <= '0;
            r_wr          <= '0;
            r_rd          <= '0;
            r_count       <= '0;
        end else begin
            if (accept) begin
                r_frame_open  <= n_frame_open;
                r_frame_stamp <= n_frame_stamp;
                r_pkt_stamp   <= n_pkt_stamp;
                r_pos         <= n_pos;
                r_sbit        <= n_sbit;
                r_ebit        <= n_ebit;
                r_hdr_start   <= n_hdr_start;
                r_skipped     <= n_skipped;
                r_carry       <= n_carry;
                r_carry_cnt   <= n_carry_cnt;
                r_wr          <= r_wr + QAW'(n_res);
            end
            if (pop) r_rd <= r_rd + QAW'(1);
            r_count <= r_count + (accept ? (QAW+1)'(n_res) : '0) - (QAW+1)'(pop);
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAXRES; k++) begin
            if (accept && (2'(k) < n_res)) begin
                r_q[r_wr + QAW'(k)] <= res[k];
            end
        end
    end

endmodule

### design/rh261_checker.sv
module rh261_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_kind,
    input logic       i_out_last
);
    import rh261_pkg::*;

    // kind is one of the three defined codes
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_kind == KIND_DATA || i_out_kind == KIND_DONE ||
                         i_out_kind == KIND_ABORT))
        else $error("illegal result kind");

    // frame complete and abort carry a zero byte and end the run
    a_ctrl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != KIND_DATA) |-> (i_out_byte == 8'h00 && i_out_last))
        else $error("control result with data or not last of run");

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_kind) &&
             $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind rtp_h261_depacketizer rh261_checker u_rh261_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.run_last)
);

### tb/rtp_h261_depacketizer_test.sv
module rtp_h261_depacketizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rh261_pkg::*;

    typedef struct {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic        mark;
        logic [31:0] stamp;
    } t_payload_req;

    logic i_clk;
    logic i_rst_n;

    rh261_in_if  in_ch ();
    rh261_out_if out_ch ();

    rtp_h261_depacketizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    t_payload_req payload_reqs[$];
    t_result      pending_results[$];
    int           fail_count = 0;
    bit           in_taken = 1'b0;

    // predictor state
    logic        in_frame  = 1'b0;
    logic [31:0] frame_ts  = '0;
    logic [31:0] pkt_ts    = '0;
    logic [2:0]  hdr_pos   = '0;
    logic [2:0]  lead_skip = '0;
    logic [2:0]  tail_skip = '0;
    logic        hdr_ok    = 1'b0;
    logic        pkt_drop  = 1'b0;
    logic [7:0]  acc_bits  = '0;
    logic [2:0]  acc_cnt   = '0;

    task automatic note_fail(input string what);
        if (fail_count < 10) begin
            $display("%s", what);
        end
        fail_count++;
    endtask

    // Works out the results one payload byte causes and queues them.
    task automatic depacketize_byte(input t_payload_req r);
        t_result     made[$];
        t_result     res;
        int          s;
        int          e;
        int          nb;
        int          cc;
        int          total;
        logic [31:0] w;
        logic [31:0] bits;
        if (r.first) begin
            hdr_pos  = '0;
            pkt_drop = 1'b0;
            pkt_ts   = r.stamp;
            if (in_frame && frame_ts != r.stamp) begin
                in_frame = 1'b0;
                acc_bits = '0;
                acc_cnt  = '0;
                made.push_back(t_result'{data: 8'h00, kind: KIND_ABORT, last: 1'b0});
            end
        end
        if (!pkt_drop) begin
            if (hdr_pos < HDR_BYTES) begin
                if (hdr_pos == 3'd0) begin
                    lead_skip = r.data[7:5];
                    tail_skip = r.data[4:2];
                    hdr_ok    = (r.data[7:5] == 3'd0);
                end else if (hdr_pos == 3'd1) begin
                    // GOBN and upper MBAP cover the whole byte
                    if (r.data != 8'h00) hdr_ok = 1'b0;
                end else if (hdr_pos == 3'd2) begin
                    if (r.data[7:2] != 6'd0) hdr_ok = 1'b0;
                end
                hdr_pos = hdr_pos + 3'd1;
                if (r.last) pkt_drop = 1'b1;
            end else begin
                if (!in_frame) begin
                    if (hdr_ok) begin
                        in_frame = 1'b1;
                        frame_ts = pkt_ts;
                        acc_bits = '0;
                        acc_cnt  = '0;
                    end else begin
                        pkt_drop = 1'b1;
                    end
                end
                if (in_frame) begin
                    s     = int'(lead_skip);
                    e     = r.last ? int'(tail_skip) : 0;
                    nb    = (s + e >= 8) ? 0 : 8 - s - e;
                    cc    = int'(acc_cnt);
                    w     = {16'h0000, acc_bits, 8'h00};
                    total = cc + nb;
                    if (nb > 0) begin
                        bits = ({24'h0, r.data} >> e) & ((32'd1 << nb) - 32'd1);
                        w    = w | (bits << (16 - cc - nb));
                    end
                    if (total >= 8) begin
                        made.push_back(t_result'{data: w[15:8], kind: KIND_DATA, last: 1'b0});
                        acc_bits = w[7:0];
                        acc_cnt  = 3'(total - 8);
                    end else begin
                        acc_bits = w[15:8];
                        acc_cnt  = 3'(total);
                    end
                    lead_skip = '0;
                    if (r.last && r.mark) begin
                        // flush partial byte, zero padded
                        if (acc_cnt != 3'd0) begin
                            made.push_back(t_result'{data: acc_bits, kind: KIND_DATA,
                                                     last: 1'b0});
                        end
                        made.push_back(t_result'{data: 8'h00, kind: KIND_DONE, last: 1'b0});
                        in_frame = 1'b0;
                        acc_bits = '0;
                        acc_cnt  = '0;
                    end
                end
                if (r.last) pkt_drop = 1'b1;
            end
        end
        if (made.size() > 0) begin
            made[made.size() - 1].last = 1'b1;
        end
        foreach (made[i]) begin
            res = made[i];
            pending_results.push_back(res);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(1, 4);
        if (r < 85) return $urandom_range(5, 10);
        return $urandom_range(11, 24);
    endfunction

    function automatic logic [31:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 32'h0000_0000;
        if (r < 20) return 32'hffff_ffff;
        return $urandom;
    endfunction

    // Header that opens a frame: SBIT, GOBN, MBAP, QUANT all zero.
    function automatic logic [31:0] start_hdr(input logic [2:0] ebit);
        logic [31:0] h;
        h = $urandom;
        h[31:29] = 3'd0;
        h[28:26] = ebit;
        h[23:16] = 8'h00;
        h[15:10] = 6'd0;
        return h;
    endfunction

    // Start header with exactly one of the start fields made nonzero.
    function automatic logic [31:0] broken_hdr();
        logic [31:0] h;
        h = start_hdr(3'($urandom_range(0, 7)));
        case ($urandom_range(0, 4))
            0: h[31:29] = 3'($urandom_range(1, 7));
            1: h[23:20] = 4'($urandom_range(1, 15));
            2: h[19:16] = 4'($urandom_range(1, 15));
            3: h[15] = 1'b1;
            default: h[14:10] = 5'($urandom_range(1, 31));
        endcase
        return h;
    endfunction

    task automatic push_req(input logic [7:0] d, input bit f, input bit l, input bit m,
                            input logic [31:0] ts);
        t_payload_req r;
        r.data  = d;
        r.first = f;
        r.last  = l;
        r.mark  = m;
        r.stamp = ts;
        payload_reqs.push_back(r);
    endtask

    // fill < 0 gives random payload bytes
    task automatic add_packet(input logic [31:0] hdr, input int len, input bit mark,
                              input logic [31:0] ts, input int fill);
        logic [7:0]  d;
        logic [31:0] st;
        bit          lst;
        bit          m;
        for (int i = 0; i < len; i++) begin
            if (i < 4) d = hdr[31 - 8 * i -: 8];
            else if (fill < 0) d = 8'($urandom);
            else d = 8'(fill);
            lst = (i == len - 1);
            m   = lst ? mark : 1'($urandom_range(0, 1));
            st  = (i == 0 || $urandom_range(0, 3) != 0) ? ts : $urandom;
            push_req(d, i == 0, lst, m, st);
        end
    endtask

    // request driver
    int drv_gap     = 0;
    int drv_stretch = 0;
    bit drv_calm    = 1'b0;

    always @(negedge i_clk) begin : drive_requests
        t_payload_req r;
        if (drv_stretch == 0) begin
            drv_calm    = ($urandom_range(0, 3) == 0);
            drv_stretch = $urandom_range(30, 150);
        end else begin
            drv_stretch--;
        end
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (drv_gap > 0) begin
                drv_gap--;
                in_ch.valid <= 1'b0;
            end else if (payload_reqs.size() > 0) begin
                r = payload_reqs.pop_front();
                in_ch.in_byte       <= r.data;
                in_ch.packet_first  <= r.first;
                in_ch.packet_last   <= r.last;
                in_ch.marker        <= r.mark;
                in_ch.rtp_timestamp <= r.stamp;
                in_ch.valid         <= 1'b1;
                drv_gap = drv_calm ? 0 : pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    int snk_stall   = 0;
    int snk_stretch = 0;
    bit snk_calm    = 1'b0;

    always @(negedge i_clk) begin : drive_ready
        logic rdy;
        if (snk_stretch == 0) begin
            snk_calm    = ($urandom_range(0, 3) == 0);
            snk_stretch = $urandom_range(30, 150);
        end else begin
            snk_stretch--;
        end
        if (snk_stall > 0) begin
            snk_stall--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
            if (!snk_calm) snk_stall = pick_gap();
        end
        out_ch.ready <= rdy;
    end

    always @(posedge i_clk) begin : watch
        t_payload_req r;
        t_result      got;
        t_result      want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                r.data  = in_ch.in_byte;
                r.first = in_ch.packet_first;
                r.last  = in_ch.packet_last;
                r.mark  = in_ch.marker;
                r.stamp = in_ch.rtp_timestamp;
                depacketize_byte(r);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.data = out_ch.out_byte;
                got.kind = out_ch.kind;
                got.last = out_ch.run_last;
                if (pending_results.size() == 0) begin
                    note_fail($sformatf("%0t: unexpected result byte=%02h kind=%0d last=%0b",
                                        $time, got.data, got.kind, got.last));
                end else begin
                    want = pending_results.pop_front();
                    if (got.data !== want.data || got.kind !== want.kind ||
                        got.last !== want.last) begin
                        note_fail($sformatf({"%0t: mismatch expected byte=%02h kind=%0d ",
                                             "last=%0b, got byte=%02h kind=%0d last=%0b"},
                                            $time, want.data, want.kind, want.last,
                                            got.data, got.kind, got.last));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int          goal;
        int          pick;
        int          npk;
        bit          mark;
        logic [31:0] ts;
        logic [31:0] hdr;

        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = '0;
        in_ch.packet_first   = 1'b0;
        in_ch.packet_last    = 1'b0;
        in_ch.marker         = 1'b0;
        in_ch.rtp_timestamp  = '0;
        out_ch.ready         = 1'b0;

        // frame open, one full payload byte
        add_packet(start_hdr(3'd0), 5, 1'b0, 32'h0000_0000, 8'hff);
        // SBIT+EBIT reach 8 on a single payload byte: no bits
        add_packet({3'd3, 3'd5, 26'h2a5_5a5a}, 5, 1'b0, 32'h0000_0000, 8'h00);
        // partial bits, marker flushes and completes
        add_packet({3'd2, 3'd3, 26'h155_a5a5}, 6, 1'b1, 32'h0000_0000, -1);
        // one-byte packet, marker ignored
        add_packet(start_hdr(3'd0), 1, 1'b1, 32'hffff_ffff, -1);
        // frame left open with one carried bit
        add_packet(start_hdr(3'd7), 5, 1'b0, 32'hffff_ffff, -1);
        // short packet with a new timestamp aborts the frame
        add_packet(32'hffff_ffff, 2, 1'b1, 32'h1234_5678, -1);
        // stray byte outside any packet
        push_req(8'ha5, 1'b0, 1'b1, 1'b1, 32'h5a5a_5a5a);

        goal = 310;
        while (payload_reqs.size() < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                ts  = pick_stamp();
                npk = $urandom_range(1, 4);
                for (int k = 0; k < npk; k++) begin
                    hdr  = (k == 0) ? start_hdr(3'($urandom_range(0, 7))) : $urandom;
                    mark = (k == npk - 1) ? ($urandom_range(0, 99) < 85)
                                          : ($urandom_range(0, 9) == 0);
                    add_packet(hdr, pick_len(), mark, ts, -1);
                end
            end else if (pick < 85) begin
                add_packet(broken_hdr(), pick_len(), 1'($urandom_range(0, 1)),
                           pick_stamp(), -1);
            end else if (pick < 93) begin
                add_packet($urandom, pick_len(), 1'($urandom_range(0, 1)), pick_stamp(), -1);
            end else begin
                npk = $urandom_range(1, 3);
                for (int k = 0; k < npk; k++) begin
                    push_req(8'($urandom), 1'b0, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), $urandom);
                end
            end
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (payload_reqs.size() != 0 || in_ch.valid !== 1'b0) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            note_fail($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (fail_count == 0) begin
            $display("rtp_h261_depacketizer_test: done, clean");
        end else begin
            $display("rtp_h261_depacketizer_test: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("rtp_h261_depacketizer_test: done, errors");
        $finish;
    end

endmodule
